### hdl/accel_tilt_angle_encoder_macros.svh
// ----------------------------------------------------------------------------
// Tilt angle encoder assertion macros
// Shared concurrent assertion forms, sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ACCEL_TILT_ANGLE_ENCODER_MACROS_SVH
`define ACCEL_TILT_ANGLE_ENCODER_MACROS_SVH

// Same-cycle implication.
`define TAE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles.
`define TAE_ASSERT_DLY(lbl, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

### hdl/tae_pkg.sv
// ----------------------------------------------------------------------------
// Tilt angle encoder package
// Widths, constants, the CORDIC lane type and the arctangent step table.
// ----------------------------------------------------------------------------
package tae_pkg;

  localparam int FRAC_BITS       = 24;
  localparam int CFG_W           = 16;
  localparam int IN_W            = 16;
  localparam int DATA_W          = 18;  // z - offset and extended axis values
  localparam int MAG_W           = 17;  // magnitude of DATA_W values
  localparam int CORDIC_W        = MAG_W + FRAC_BITS + 3;
  localparam int ANGLE_W         = 27;
  localparam int Q_W             = 16;  // centi-units before the divide by 314
  localparam int DEG_W           = 7;
  localparam int CODE_W          = 11;
  localparam int LANES           = 2;
  localparam int SCALE_W         = 15;
  localparam int DIV_W           = 9;

  localparam int CORDIC_STAGES_DEF = 24;
  localparam int SAMPLE_BITS_DEF   = 16;

  localparam logic signed [CFG_W-1:0] Z_OFFSET_RESET = 16'sd1900;
  localparam logic [SCALE_W-1:0]      DEG_SCALE      = 15'd18000;
  localparam logic [DIV_W-1:0]        DEG_DIV        = 9'd314;
  localparam logic [DEG_W-1:0]        DEG_MAX        = 7'd90;
  localparam logic [CODE_W-1:0]       NEG_BIAS       = 11'd1000;
  localparam logic [CODE_W-1:0]       CODE_MAX       = 11'd1090;
  localparam logic [Q_W-1:0]          Q_SAT          = 16'd28574;  // 91 * 314

  typedef struct packed {
    logic                       v_zero;
    logic                       d_zero;
    logic                       neg;
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [ANGLE_W-1:0]  a;
  } lane_t;

  // round(atan(2^-i) * 2^24)
  function automatic logic signed [ANGLE_W-1:0] atan_step(input int i);
    case (i)
      0:       return 27'sd13176795;
      1:       return 27'sd7778716;
      2:       return 27'sd4110060;
      3:       return 27'sd2086331;
      4:       return 27'sd1047214;
      5:       return 27'sd524117;
      6:       return 27'sd262123;
      7:       return 27'sd131069;
      8:       return 27'sd65536;
      9:       return 27'sd32768;
      10:      return 27'sd16384;
      11:      return 27'sd8192;
      12:      return 27'sd4096;
      13:      return 27'sd2048;
      14:      return 27'sd1024;
      15:      return 27'sd512;
      16:      return 27'sd256;
      17:      return 27'sd128;
      18:      return 27'sd64;
      19:      return 27'sd32;
      20:      return 27'sd16;
      21:      return 27'sd8;
      22:      return 27'sd4;
      23:      return 27'sd2;
      24:      return 27'sd1;
      default: return '0;
    endcase
  endfunction

endpackage

### hdl/tae_cell.sv
// ----------------------------------------------------------------------------
// Tilt angle encoder CORDIC cell
// One vectoring micro-rotation for both axis lanes, registered.
// ----------------------------------------------------------------------------
module tae_cell #(
  parameter int STAGE = 0
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  tae_pkg::lane_t [tae_pkg::LANES-1:0] in_lanes,
  output logic                                out_valid,
  output tae_pkg::lane_t [tae_pkg::LANES-1:0] out_lanes
);

  localparam logic signed [tae_pkg::ANGLE_W-1:0] ANG = tae_pkg::atan_step(STAGE);

  tae_pkg::lane_t [tae_pkg::LANES-1:0] lanes_next;
  logic signed [tae_pkg::CORDIC_W-1:0] x_cur [tae_pkg::LANES];
  logic signed [tae_pkg::CORDIC_W-1:0] y_cur [tae_pkg::LANES];
  logic signed [tae_pkg::CORDIC_W-1:0] x_sh  [tae_pkg::LANES];
  logic signed [tae_pkg::CORDIC_W-1:0] y_sh  [tae_pkg::LANES];

  always_comb begin
    for (int l = 0; l < tae_pkg::LANES; l++) begin
      lanes_next[l] = in_lanes[l];
      x_cur[l]      = in_lanes[l].x;
      y_cur[l]      = in_lanes[l].y;
      x_sh[l]       = x_cur[l] >>> STAGE;
      y_sh[l]       = y_cur[l] >>> STAGE;
      // rotate toward the x axis
      if (!y_cur[l][tae_pkg::CORDIC_W-1]) begin
        lanes_next[l].x = x_cur[l] + y_sh[l];
        lanes_next[l].y = y_cur[l] - x_sh[l];
        lanes_next[l].a = in_lanes[l].a + ANG;
      end else begin
        lanes_next[l].x = x_cur[l] - y_sh[l];
        lanes_next[l].y = y_cur[l] + x_sh[l];
        lanes_next[l].a = in_lanes[l].a - ANG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_lanes <= lanes_next;
  end

endmodule

### hdl/tae_code.sv
// ----------------------------------------------------------------------------
// Tilt angle encoder code stage
// Turn a CORDIC angle into whole degrees and the signed tilt code.
// Two register stages: scale, then divide by 314 and encode.
// ----------------------------------------------------------------------------
module tae_code (
  input  logic                          clk,
  input  tae_pkg::lane_t                in_lane,
  output logic [tae_pkg::CODE_W-1:0]    code
);

  localparam int POS_W  = tae_pkg::ANGLE_W - 1;
  localparam int PROD_W = POS_W + tae_pkg::SCALE_W;

  logic [POS_W-1:0]           a_pos;
  logic [PROD_W-1:0]          prod;
  logic [tae_pkg::Q_W-1:0]    q;
  logic                       v_zero;
  logic                       d_zero;
  logic                       neg;
  logic [tae_pkg::Q_W-1:0]    rem;
  logic [tae_pkg::Q_W-1:0]    trial;
  logic [tae_pkg::DEG_W-1:0]  deg;
  logic [tae_pkg::CODE_W-1:0] deg_ext;
  logic [tae_pkg::CODE_W-1:0] code_next;

  // Stage 1: clamp negative angles to zero and scale by 18000 / 2^24.
  always_comb begin
    a_pos = in_lane.a[tae_pkg::ANGLE_W-1] ? '0 : in_lane.a[POS_W-1:0];
    prod  = PROD_W'(a_pos) * PROD_W'(tae_pkg::DEG_SCALE);
  end

  always_ff @(posedge clk) begin
    q      <= prod[tae_pkg::FRAC_BITS +: tae_pkg::Q_W];
    v_zero <= in_lane.v_zero;
    d_zero <= in_lane.d_zero;
    neg    <= in_lane.neg;
  end

  // Stage 2: restoring divide by 314, saturate at 90, encode.
  always_comb begin
    rem   = q;
    deg   = '0;
    trial = '0;
    if (q >= tae_pkg::Q_SAT) begin
      deg = tae_pkg::DEG_MAX;
    end else begin
      for (int k = tae_pkg::DEG_W - 1; k >= 0; k--) begin
        trial = tae_pkg::Q_W'(tae_pkg::DEG_DIV) << k;
        if (rem >= trial) begin
          rem    = rem - trial;
          deg[k] = 1'b1;
        end
      end
    end
    if (d_zero) begin
      deg = tae_pkg::DEG_MAX;
    end
    deg_ext = tae_pkg::CODE_W'(deg);
    if (v_zero) begin
      code_next = tae_pkg::NEG_BIAS;
    end else if (!neg && (deg != '0)) begin
      code_next = deg_ext;
    end else begin
      code_next = tae_pkg::NEG_BIAS + deg_ext;
    end
  end

  always_ff @(posedge clk) begin
    code <= code_next;
  end

endmodule

### hdl/accel_tilt_angle_encoder.sv
// ----------------------------------------------------------------------------
// Accelerometer tilt angle encoder
// Pipelined CORDIC arctangent of x/(z - offset) and y/(z - offset) in degrees.
// ----------------------------------------------------------------------------
// The block takes one sample every clock cycle: start is accepted whenever
// busy is low, and busy is high only while rst is held. Each transaction
// returns one result, shown on tilt_x_code / tilt_y_code for the single cycle
// in which done is high, after the input register, one row cell per CORDIC
// iteration and the code registers that scale, divide by 314 and encode. The
// receiver cannot stall, so results stream out in order at the input rate.
// Codes: a positive tilt in degrees reads as is, a zero or negative tilt reads
// 1000 plus its magnitude. The user must write z_offset (reset 1900) via
// cfg_we / cfg_wdata while no transaction is in flight; nothing enforces it.
// ----------------------------------------------------------------------------
`include "accel_tilt_angle_encoder_macros.svh"

module accel_tilt_angle_encoder #(
  parameter int CORDIC_STAGES = tae_pkg::CORDIC_STAGES_DEF,
  parameter int SAMPLE_BITS   = tae_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [tae_pkg::IN_W-1:0]    accel_x,
  input  logic signed [tae_pkg::IN_W-1:0]    accel_y,
  input  logic signed [tae_pkg::IN_W-1:0]    accel_z,
  input  logic                               cfg_we,
  input  logic signed [tae_pkg::CFG_W-1:0]   cfg_wdata,
  output logic                               done,
  output logic [tae_pkg::CODE_W-1:0]         tilt_x_code,
  output logic [tae_pkg::CODE_W-1:0]         tilt_y_code
);

  localparam int LATENCY = CORDIC_STAGES + 3;
  localparam int DW      = tae_pkg::DATA_W;
  localparam int MW      = tae_pkg::MAG_W;
  localparam int PAD_W   = tae_pkg::CORDIC_W - MW - tae_pkg::FRAC_BITS;

  logic signed [tae_pkg::CFG_W-1:0]    z_offset;
  logic signed [SAMPLE_BITS-1:0]       samp [3];
  logic signed [DW-1:0]                samp_ext [3];
  logic signed [DW-1:0]                denom;
  logic signed [DW-1:0]                d_abs;
  logic signed [DW-1:0]                v_abs;
  logic [MW-1:0]                       d_mag;
  logic [MW-1:0]                       v_mag;
  tae_pkg::lane_t [tae_pkg::LANES-1:0] lanes_next;
  logic                                accept;

  logic                                cell_valid [CORDIC_STAGES+1];
  tae_pkg::lane_t [tae_pkg::LANES-1:0] cell_lanes [CORDIC_STAGES+1];
  logic                                post_valid;

  // Hold off transactions only while reset is applied.
  assign busy   = rst;
  assign accept = start && !busy;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      z_offset <= tae_pkg::Z_OFFSET_RESET;
    end else if (cfg_we) begin
      z_offset <= cfg_wdata;
    end
  end

  // Front end: sign extend the samples, form the denominator and seed the
  // CORDIC lanes with the magnitudes in fixed point with 24 fraction bits.
  always_comb begin
    samp[0] = accel_x[SAMPLE_BITS-1:0];
    samp[1] = accel_y[SAMPLE_BITS-1:0];
    samp[2] = accel_z[SAMPLE_BITS-1:0];
    for (int i = 0; i < 3; i++) begin
      samp_ext[i] = {{(DW-SAMPLE_BITS){samp[i][SAMPLE_BITS-1]}}, samp[i]};
    end
    denom = samp_ext[2] - {{(DW-tae_pkg::CFG_W){z_offset[tae_pkg::CFG_W-1]}}, z_offset};
    d_abs = denom[DW-1] ? -denom : denom;
    d_mag = d_abs[MW-1:0];
    v_abs = '0;
    v_mag = '0;
    for (int l = 0; l < tae_pkg::LANES; l++) begin
      v_abs = samp_ext[l][DW-1] ? -samp_ext[l] : samp_ext[l];
      v_mag = v_abs[MW-1:0];
      lanes_next[l].v_zero = (samp_ext[l] == '0);
      lanes_next[l].d_zero = (denom == '0);
      // the sign of v alone when the denominator is zero
      lanes_next[l].neg    = samp_ext[l][DW-1] ^ denom[DW-1];
      lanes_next[l].x      = {{PAD_W{1'b0}}, d_mag, {tae_pkg::FRAC_BITS{1'b0}}};
      lanes_next[l].y      = {{PAD_W{1'b0}}, v_mag, {tae_pkg::FRAC_BITS{1'b0}}};
      lanes_next[l].a      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_valid[0] <= 1'b0;
    end else begin
      cell_valid[0] <= accept;
    end
    cell_lanes[0] <= lanes_next;
  end

  // CORDIC row: one cell per iteration, data moves one cell every cycle.
  for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_cell
    tae_cell #(
      .STAGE(s)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .in_valid (cell_valid[s]),
      .in_lanes (cell_lanes[s]),
      .out_valid(cell_valid[s+1]),
      .out_lanes(cell_lanes[s+1])
    );
  end

  // Degree conversion and encoding, one unit per lane.
  tae_code u_code_x (
    .clk    (clk),
    .in_lane(cell_lanes[CORDIC_STAGES][0]),
    .code   (tilt_x_code)
  );

  tae_code u_code_y (
    .clk    (clk),
    .in_lane(cell_lanes[CORDIC_STAGES][1]),
    .code   (tilt_y_code)
  );

  // Advance the valid strobe alongside the code stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      post_valid <= 1'b0;
      done       <= 1'b0;
    end else begin
      post_valid <= cell_valid[CORDIC_STAGES];
      done       <= post_valid;
    end
  end

  `TAE_ASSERT_DLY(a_result_follows, accept, LATENCY, done, "accepted sample produced no result")
  `TAE_ASSERT_IMP(a_no_phantom, done, $past(accept, LATENCY), "result without a sample")
  `TAE_ASSERT_IMP(a_x_code_form, done && (tilt_x_code > 11'd90), (tilt_x_code >= tae_pkg::NEG_BIAS) && (tilt_x_code <= tae_pkg::CODE_MAX), "x code outside encoding")
  `TAE_ASSERT_IMP(a_y_code_form, done && (tilt_y_code > 11'd90), (tilt_y_code >= tae_pkg::NEG_BIAS) && (tilt_y_code <= tae_pkg::CODE_MAX), "y code outside encoding")

endmodule
